/* rtl/rlpf_pkg.sv */
package rlpf_pkg;

   localparam int PORT_FRAC_BITS = 15;

   localparam logic [16:0] DAMP_MUL   = 17'h0E666;
   localparam logic [16:0] DAMP_UNITY = 17'd32768;

   localparam logic [15:0] FEED_GAIN_RESET = 16'd4096;
   localparam logic [15:0] DAMP_CODE_RESET = 16'd0;

   localparam logic [1:0] CSR_FEED_GAIN = 2'd0;
   localparam logic [1:0] CSR_DAMP_CODE = 2'd1;
   localparam logic [1:0] CSR_BOOST     = 2'd2;

   localparam logic signed [49:0] VEL_MAX = 50'sd2147483647;
   localparam logic signed [49:0] VEL_MIN = -50'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > VEL_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < VEL_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/resonant_lowpass_filter.sv */
// Two-pole resonant lowpass filter with a position and a velocity state. One
// 32 by 17 bit multiplier is shared under a small sequencer and is used three
// times per sample (feed gain, damping factor, damping), so req_tready stays low
// from each input transfer until the sequence is back in S_IDLE, and a new sample
// is taken only once the last is through. The result is registered in S_POS, after
// S_GAIN and S_VEL; if the previous result has not been taken, the sequencer waits for it.
// Ports use 1.0 = 32768, the internal state uses 1.0 = 2^STATE_FRAC_BITS.
module resonant_lowpass_filter #(
   parameter int STATE_FRAC_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample [15:0], seed_sample [31:16]
   input  logic [1:0]  req_tuser,   // buffer_start [0], reseed [1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // filtered_sample [17:0], zero fill [23:18]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int PW = STATE_FRAC_BITS + 2;
   localparam int UP_SHIFT = STATE_FRAC_BITS - rlpf_pkg::PORT_FRAC_BITS;
   localparam logic signed [33:0] POS_ONE = 34'sd1 <<< STATE_FRAC_BITS;
   localparam logic signed [33:0] POS_NEG_ONE = -POS_ONE;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_GAIN = 3'd1;
   localparam logic [2:0] S_VEL  = 3'd2;
   localparam logic [2:0] S_POS  = 3'd3;
   localparam logic [2:0] S_DFAC = 3'd4;
   localparam logic [2:0] S_DMUL = 3'd5;
   localparam logic [2:0] S_DAMP = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [15:0] feed_gain_ff, damp_code_ff;
   logic boost_ff;
   logic signed [PW-1:0] pos_ff, pos_in;
   logic signed [31:0] vel_ff, vel_in;
   logic signed [PW-1:0] x_ff, x_in;
   logic signed [48:0] prod_ff, prod_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [17:0] rsp_data_ff, rsp_data_in;

   logic req_xfer, slot_free;
   logic signed [PW-1:0] sample_up, seed_up, sample_q, seed_q, diff;
   logic signed [16:0] code_diff;
   logic signed [15:0] dfac;
   logic signed [31:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [48:0] mul_p;
   logic signed [49:0] vel_sum;
   logic signed [33:0] pos_sum, pos_clamp;
   logic signed [16:0] y_port;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_data_ff};

   assign sample_up = PW'($signed(req_tdata[15:0])) <<< UP_SHIFT;
   assign seed_up   = PW'($signed(req_tdata[31:16])) <<< UP_SHIFT;
   assign sample_q  = sample_up >>> 2;
   assign seed_q    = seed_up >>> 2;
   assign diff      = x_ff - pos_ff;
   assign code_diff = $signed(rlpf_pkg::DAMP_UNITY - {1'b0, damp_code_ff});
   assign dfac      = $signed(prod_ff[31:16]);

   always_comb begin
      mul_a = 32'(diff);
      mul_b = $signed({1'b0, feed_gain_ff});
      case (state_ff)
         S_DFAC: begin
            mul_a = 32'(code_diff);
            mul_b = $signed(rlpf_pkg::DAMP_MUL);
         end
         S_DMUL: begin
            mul_a = vel_ff;
            mul_b = 17'(dfac);
         end
         default: begin
            mul_a = 32'(diff);
            mul_b = $signed({1'b0, feed_gain_ff});
         end
      endcase
   end

   assign mul_p   = 49'(mul_a) * 49'(mul_b);
   assign vel_sum = 50'(vel_ff) + 50'(prod_ff >>> 12);
   assign pos_sum = 34'(pos_ff) + 34'(vel_ff);

   always_comb begin
      if (pos_sum > POS_ONE) begin
         pos_clamp = POS_ONE;
      end else if (pos_sum < POS_NEG_ONE) begin
         pos_clamp = POS_NEG_ONE;
      end else begin
         pos_clamp = pos_sum;
      end
   end

   assign y_port = 17'(pos_clamp >>> UP_SHIFT);

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      x_in         = x_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               x_in = sample_q;
               if (req_tuser[0]) begin
                  vel_in = '0;
               end
               if (req_tuser[1]) begin
                  pos_in = seed_q;
               end
               state_in = S_GAIN;
            end
         end
         S_GAIN: begin
            prod_in  = mul_p;
            state_in = S_VEL;
         end
         S_VEL: begin
            vel_in   = rlpf_pkg::sat32(vel_sum);
            state_in = S_POS;
         end
         S_POS: begin
            if (slot_free) begin
               pos_in       = PW'(pos_clamp);
               rsp_valid_in = 1'b1;
               rsp_data_in  = boost_ff ? (18'(y_port) <<< 1) : 18'(y_port);
               state_in     = S_DFAC;
            end
         end
         S_DFAC: begin
            prod_in  = mul_p;
            state_in = S_DMUL;
         end
         S_DMUL: begin
            prod_in  = mul_p;
            state_in = S_DAMP;
         end
         S_DAMP: begin
            vel_in   = rlpf_pkg::sat32(50'(prod_ff >>> 15));
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pos_ff       <= '0;
         vel_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         feed_gain_ff <= rlpf_pkg::FEED_GAIN_RESET;
         damp_code_ff <= rlpf_pkg::DAMP_CODE_RESET;
         boost_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         vel_ff       <= vel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_addr)
               rlpf_pkg::CSR_FEED_GAIN: feed_gain_ff <= csr_wdata;
               rlpf_pkg::CSR_DAMP_CODE: damp_code_ff <= csr_wdata;
               rlpf_pkg::CSR_BOOST:     boost_ff     <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_pos_bounded: assert property (@(posedge clock) disable iff (reset)
      (34'(pos_ff) <= POS_ONE) && (34'(pos_ff) >= POS_NEG_ONE))
      else $error("Position left the range of plus or minus one.");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_GAIN))
      else $error("An input transfer did not start the sequence.");

   a_pos_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POS && rsp_valid_ff && !rsp_tready) |=> (state_ff == S_POS))
      else $error("The sequencer overwrote a result that was not taken.");

   a_rsp_from_pos: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_POS))
      else $error("A result appeared outside the output step.");

endmodule

/* tb/sv/tb_resonant_lowpass_filter.sv */
`timescale 1ns / 100ps

module tb_resonant_lowpass_filter;

   localparam int FRAC_BITS = 20;
   localparam int SETTLE_CYCLES = 12;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // sample [15:0], seed_sample [31:16]
   logic [1:0]  req_tuser;   // buffer_start [0], reseed [1]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;   // filtered_sample [17:0], zero fill [23:18]
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_addr;
   logic [15:0] csr_wdata;

   logic [15:0] feed_gain_q;
   logic [15:0] damp_code_q;
   logic        boost_q;
   longint      position_q;
   longint      velocity_q;

   logic [17:0] expected_outputs[$];
   int          mismatches = 0;
   int          idle_pct = 0;
   int          stall_left = 0;
   logic [17:0] want_output;

   resonant_lowpass_filter #(
      .STATE_FRAC_BITS(FRAC_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint quarter_scale(input logic signed [15:0] v);
      return (longint'(v) <<< (FRAC_BITS - rlpf_pkg::PORT_FRAC_BITS)) >>> 2;
   endfunction

   function automatic longint clamp_velocity(input longint v);
      if (v > longint'(32'sh7FFF_FFFF)) begin
         return longint'(32'sh7FFF_FFFF);
      end else if (v < longint'(32'sh8000_0000)) begin
         return longint'(32'sh8000_0000);
      end
      return v;
   endfunction

   function automatic logic [17:0] filter_step(input logic [15:0] sample, input bit buf_start,
                                               input bit reseed, input logic [15:0] seed);
      longint      one;
      longint      x;
      longint      y;
      longint      d;
      logic [31:0] damp_prod;
      one = longint'(1) <<< FRAC_BITS;
      x = quarter_scale(sample);
      if (buf_start) begin
         velocity_q = 0;
      end
      if (reseed) begin
         position_q = quarter_scale(seed);
      end
      velocity_q = clamp_velocity(velocity_q + (((x - position_q) * longint'(feed_gain_q)) >>> 12));
      position_q = position_q + velocity_q;
      if (position_q > one) begin
         position_q = one;
      end else if (position_q < -one) begin
         position_q = -one;
      end
      y = position_q >>> (FRAC_BITS - rlpf_pkg::PORT_FRAC_BITS);
      if (boost_q) begin
         y = y * 2;
      end
      damp_prod = (32'd32768 - {16'b0, damp_code_q}) * 32'h0000_E666;
      d = longint'($signed(damp_prod[31:16]));
      velocity_q = clamp_velocity((velocity_q * d) >>> 15);
      return y[17:0];
   endfunction

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7, 0))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($signed($urandom_range(2047, 0)) - 1024);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [17:0] want,
                                  input logic [17:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t: %s: expected %0d, got %0d", $time, what, $signed(want), $signed(got));
      end
   endtask

   task automatic send_sample(input logic [15:0] sample, input bit buf_start, input bit reseed,
                              input logic [15:0] seed);
      int gap;
      if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
         gap = $urandom_range(19, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {seed, sample};
      req_tuser <= {reseed, buf_start};
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_outputs.push_back(filter_step(sample, buf_start, reseed, seed));
   endtask

   task automatic wait_until_drained(input int settle);
      req_tvalid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic csr_transfer(input logic [1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         rlpf_pkg::CSR_FEED_GAIN: feed_gain_q = value;
         rlpf_pkg::CSR_DAMP_CODE: damp_code_q = value;
         rlpf_pkg::CSR_BOOST:     boost_q = value[0];
         default: ;
      endcase
   endtask

   task automatic set_filter(input logic [15:0] gain, input logic [15:0] damp, input bit boost);
      wait_until_drained(SETTLE_CYCLES);
      csr_transfer(rlpf_pkg::CSR_FEED_GAIN, gain);
      csr_transfer(rlpf_pkg::CSR_DAMP_CODE, damp);
      csr_transfer(rlpf_pkg::CSR_BOOST, {15'b0, boost});
      csr_valid <= 1'b0;
   endtask

   task automatic test_default_settings();
      send_sample(16'h7FFF, 1'b1, 1'b0, 16'h0000);
      send_sample(16'h7FFF, 1'b0, 1'b0, 16'h0000);
      send_sample(16'h8000, 1'b0, 1'b0, 16'hFFFF);
      send_sample(16'h0000, 1'b0, 1'b1, 16'h8000);
      send_sample(16'h0000, 1'b1, 1'b1, 16'h7FFF);
   endtask

   task automatic test_register_extremes();
      // Full gain with a damping code above unity, which makes the damping factor negative.
      set_filter(16'hFFFF, 16'hFFFF, 1'b1);
      send_sample(16'h7FFF, 1'b1, 1'b1, 16'h8000);
      send_sample(16'h8000, 1'b0, 1'b0, 16'h0000);
      send_sample(16'h7FFF, 1'b0, 1'b0, 16'h0000);
      send_sample(16'h8000, 1'b0, 1'b0, 16'h0000);
      set_filter(16'h0000, 16'h8000, 1'b1);
      send_sample(16'h7FFF, 1'b0, 1'b0, 16'h0000);
      send_sample(16'h8000, 1'b0, 1'b1, 16'h7FFF);
      send_sample(16'h1234, 1'b1, 1'b0, 16'h0000);
      set_filter(16'hFFFF, 16'h8001, 1'b0);
      send_sample(16'h7FFF, 1'b1, 1'b0, 16'h0000);
      send_sample(16'h8000, 1'b0, 1'b0, 16'h0000);
      send_sample(16'h4000, 1'b0, 1'b1, 16'hC000);
      set_filter(16'h1000, 16'h0000, 1'b0);
      send_sample(16'h8000, 1'b1, 1'b1, 16'h8000);
      send_sample(16'h7FFF, 1'b0, 1'b0, 16'h0000);
   endtask

   task automatic run_buffer_stream(input int items, input int pct);
      int          sent;
      int          buf_left;
      int          pause_at;
      logic [15:0] s;
      logic [15:0] last;
      idle_pct = pct;
      sent = 0;
      buf_left = 0;
      last = 16'h0000;
      pause_at = $urandom_range(items - 1, 1);
      while (sent < items) begin
         if (sent == pause_at) begin
            wait_until_drained(1);
         end
         s = pick_sample();
         if (buf_left == 0) begin
            buf_left = $urandom_range(32, 1);
            if ($urandom_range(9, 0) == 0) begin
               send_sample(s, 1'($urandom), 1'($urandom), pick_sample());
            end else begin
               send_sample(s, 1'b1, $urandom_range(3, 0) != 0, last);
            end
         end else if ($urandom_range(19, 0) == 0) begin
            send_sample(s, 1'($urandom), 1'($urandom), pick_sample());
         end else begin
            send_sample(s, 1'b0, 1'b0, 16'($urandom));
         end
         last = s;
         buf_left--;
         sent++;
      end
   endtask

   task automatic test_random_settings();
      logic [15:0] gain;
      logic [15:0] damp;
      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(3, 0))
            0: gain = 16'h0000;
            1: gain = 16'hFFFF;
            2: gain = 16'($urandom_range(8191, 0));
            default: gain = 16'($urandom);
         endcase
         case ($urandom_range(4, 0))
            0: damp = 16'h0000;
            1: damp = 16'h8000;
            2: damp = 16'hFFFF;
            3: damp = 16'($urandom);
            default: damp = 16'($urandom_range(32768, 0));
         endcase
         set_filter(gain, damp, 1'($urandom));
         if (phase == 7 || phase % 3 == 0) begin
            run_buffer_stream(120, 0);
         end else begin
            run_buffer_stream(120, 30);
         end
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_outputs.size() == 0) begin
            report_mismatch("unexpected result", 18'd0, rsp_tdata[17:0]);
         end else begin
            want_output = expected_outputs.pop_front();
            if (rsp_tdata[17:0] !== want_output) begin
               report_mismatch("filtered_sample", want_output, rsp_tdata[17:0]);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct / 3) begin
         stall_left = $urandom_range(19, 1) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      csr_valid <= 1'b0;
      csr_addr <= rlpf_pkg::CSR_FEED_GAIN;
      csr_wdata <= '0;
      feed_gain_q = rlpf_pkg::FEED_GAIN_RESET;
      damp_code_q = rlpf_pkg::DAMP_CODE_RESET;
      boost_q = 1'b0;
      position_q = 0;
      velocity_q = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_register_extremes();
      test_random_settings();
      wait_until_drained(SETTLE_CYCLES);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
